/* rtl/sprite_run_length_decoder_top_assert.svh */
// assertion macros for the sprite run-length decoder
// used by sprite_run_length_decoder_top; expects clk and rst_n in scope
`ifndef SPRITE_RUN_LENGTH_DECODER_TOP_ASSERT_SVH
`define SPRITE_RUN_LENGTH_DECODER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SRLD_ASSERT_IMPLY(label, cond, expect_expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_expr)) \
        else $error("srld same-cycle check failed");

// next-cycle implication, checked out of reset
`define SRLD_ASSERT_NEXT(label, cond, expect_expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_expr)) \
        else $error("srld next-cycle check failed");

`endif

/* rtl/srld_pkg.sv */
// shared types and codes for the sprite run-length decoder
// no dependencies
`default_nettype none

package srld_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_LINE_MISMATCH = 3'd1,
        ERR_RUNCOUNT_OVR  = 3'd2,
        ERR_HEADER_OVR    = 3'd3,
        ERR_OFFSET_WIDE   = 3'd4,
        ERR_DATA_OVR      = 3'd5,
        ERR_DATA_WIDE     = 3'd6
    } err_t;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FRAME_WORDS  = 2'd2;

    localparam int DIM_W   = 13;
    localparam int WORDS_W = 20;
    localparam int COORD_W = 12;

    // one result beat
    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               frame_end;
        err_t               error_code;
    } result_t;

endpackage

`default_nettype wire

/* rtl/sprite_run_length_decoder_top.sv */
// Throughput: one word per cycle while results are not stalled; each word sees one pass of parse
// logic between the input and result registers, with parse state updated in the same cycle.
// Reset: parser waits for a frame start, counters clear, registers reset to 1.
// Config port is always ready; writes apply to words processed afterwards.
// depends on srld_pkg and sprite_run_length_decoder_top_assert.svh
`default_nettype none

module sprite_run_length_decoder_top #(
    parameter int unsigned MAX_DIMENSION   = 4096,
    parameter int unsigned MAX_FRAME_WORDS = 1048576
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // word channel
    input  wire logic        word_valid,
    output logic             word_stall,
    input  wire logic        frame_start,
    input  wire logic [15:0] data_word,
    // result channel
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       kind,
    output logic [11:0]      pixel_x,
    output logic [11:0]      pixel_y,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic             frame_end,
    output logic [2:0]       error_code,
    // configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);

    localparam int DW = srld_pkg::DIM_W;
    localparam int WW = srld_pkg::WORDS_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RUNCOUNT,
        PH_OFFSET,
        PH_LENGTH,
        PH_PIXEL,
        PH_HOLD
    } phase_t;

    // configuration registers
    logic [DW-1:0] frame_width_reg;
    logic [DW-1:0] frame_height_reg;
    logic [WW-1:0] frame_words_reg;

    // input stage
    logic          in_valid_reg;
    logic          in_start_reg;
    logic [15:0]   in_word_reg;

    // parse state
    phase_t        phase_reg, phase_next;
    logic [DW-1:0] line_index_reg, line_index_next;
    logic [DW-1:0] column_reg, column_next;
    logic [15:0]   runs_left_reg, runs_left_next;
    logic [15:0]   pixels_left_reg, pixels_left_next;
    logic [WW-1:0] word_position_reg, word_position_next;

    // result stage
    logic              out_valid_reg;
    srld_pkg::result_t result_reg, result_next;
    logic              has_result;

    logic          advance;
    logic          accept;
    logic [DW-1:0] width_eff;
    logic [DW-1:0] height_eff;
    logic [WW-1:0] end_eff;
    logic [DW-1:0] line_inc;
    logic          line_last;
    logic [15:0]   runs_dec;
    logic [15:0]   pixels_dec;
    logic [16:0]   col_sum;
    logic [WW:0]   pos_plus2;
    logic [WW:0]   pos_plus_len;

    // handshakes
    assign cfg_ready    = 1'b1;
    assign advance      = in_valid_reg && (!out_valid_reg || !result_stall);
    assign word_stall   = in_valid_reg && !advance;
    assign accept       = word_valid && !word_stall;
    assign result_valid = out_valid_reg;

    // register values above the caps act as the cap
    assign width_eff  = (32'(frame_width_reg) > 32'(MAX_DIMENSION))
                      ? DW'(MAX_DIMENSION) : frame_width_reg;
    assign height_eff = (32'(frame_height_reg) > 32'(MAX_DIMENSION))
                      ? DW'(MAX_DIMENSION) : frame_height_reg;
    assign end_eff    = (32'(frame_words_reg) > 32'(MAX_FRAME_WORDS))
                      ? WW'(MAX_FRAME_WORDS) : frame_words_reg;

    // shared arithmetic for the parse step
    assign line_inc     = line_index_reg + DW'(1);
    assign line_last    = (line_inc >= height_eff);
    assign runs_dec     = runs_left_reg - 16'd1;
    assign pixels_dec   = pixels_left_reg - 16'd1;
    assign col_sum      = {4'b0, column_reg} + {1'b0, in_word_reg};
    assign pos_plus2    = {1'b0, word_position_reg} + (WW+1)'(2);
    assign pos_plus_len = {1'b0, word_position_reg} + (WW+1)'(1) + (WW+1)'(in_word_reg);

    // parse step for the word in the input stage
    always_comb
    begin
        phase_next         = phase_reg;
        line_index_next    = line_index_reg;
        column_next        = column_reg;
        runs_left_next     = runs_left_reg;
        pixels_left_next   = pixels_left_reg;
        word_position_next = word_position_reg;
        has_result         = 1'b0;
        result_next        = '0;
        result_next.kind       = srld_pkg::KIND_PIXEL;
        result_next.error_code = srld_pkg::ERR_NONE;

        if (in_start_reg)
        begin
            // frame start restarts the parse from the line count word
            line_index_next    = '0;
            column_next        = '0;
            runs_left_next     = '0;
            pixels_left_next   = '0;
            word_position_next = WW'(1);
            if (in_word_reg != {3'b0, height_eff})
            begin
                phase_next             = PH_HOLD;
                has_result             = 1'b1;
                result_next.kind       = srld_pkg::KIND_ERROR;
                result_next.error_code = srld_pkg::ERR_LINE_MISMATCH;
            end
            else if (height_eff == '0)
            begin
                phase_next            = PH_HOLD;
                has_result            = 1'b1;
                result_next.kind      = srld_pkg::KIND_DONE;
                result_next.frame_end = 1'b1;
            end
            else
            begin
                phase_next = PH_RUNCOUNT;
            end
        end
        else
        begin
            if (phase_reg != PH_IDLE && phase_reg != PH_HOLD)
            begin
                word_position_next = word_position_reg + WW'(1);
            end
            case (phase_reg)
                PH_RUNCOUNT:
                begin
                    if (word_position_reg >= end_eff)
                    begin
                        phase_next             = PH_HOLD;
                        has_result             = 1'b1;
                        result_next.kind       = srld_pkg::KIND_ERROR;
                        result_next.error_code = srld_pkg::ERR_RUNCOUNT_OVR;
                    end
                    else
                    begin
                        runs_left_next = in_word_reg;
                        if (in_word_reg == 16'd0)
                        begin
                            // empty line closes at once
                            line_index_next = line_inc;
                            column_next     = '0;
                            phase_next      = line_last ? PH_HOLD : PH_RUNCOUNT;
                            if (line_last)
                            begin
                                has_result            = 1'b1;
                                result_next.kind      = srld_pkg::KIND_DONE;
                                result_next.frame_end = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = PH_OFFSET;
                        end
                    end
                end
                PH_OFFSET:
                begin
                    if (pos_plus2 > {1'b0, end_eff})
                    begin
                        phase_next             = PH_HOLD;
                        has_result             = 1'b1;
                        result_next.kind       = srld_pkg::KIND_ERROR;
                        result_next.error_code = srld_pkg::ERR_HEADER_OVR;
                    end
                    else if (col_sum > {4'b0, width_eff})
                    begin
                        phase_next             = PH_HOLD;
                        has_result             = 1'b1;
                        result_next.kind       = srld_pkg::KIND_ERROR;
                        result_next.error_code = srld_pkg::ERR_OFFSET_WIDE;
                    end
                    else
                    begin
                        column_next = col_sum[DW-1:0];
                        phase_next  = PH_LENGTH;
                    end
                end
                PH_LENGTH:
                begin
                    if (pos_plus_len > {1'b0, end_eff})
                    begin
                        phase_next             = PH_HOLD;
                        has_result             = 1'b1;
                        result_next.kind       = srld_pkg::KIND_ERROR;
                        result_next.error_code = srld_pkg::ERR_DATA_OVR;
                    end
                    else if (col_sum > {4'b0, width_eff})
                    begin
                        phase_next             = PH_HOLD;
                        has_result             = 1'b1;
                        result_next.kind       = srld_pkg::KIND_ERROR;
                        result_next.error_code = srld_pkg::ERR_DATA_WIDE;
                    end
                    else
                    begin
                        pixels_left_next = in_word_reg;
                        if (in_word_reg == 16'd0)
                        begin
                            // zero-length run closes the run, maybe the line
                            runs_left_next = runs_dec;
                            if (runs_dec == 16'd0)
                            begin
                                line_index_next = line_inc;
                                column_next     = '0;
                                phase_next      = line_last ? PH_HOLD : PH_RUNCOUNT;
                                if (line_last)
                                begin
                                    has_result            = 1'b1;
                                    result_next.kind      = srld_pkg::KIND_DONE;
                                    result_next.frame_end = 1'b1;
                                end
                            end
                            else
                            begin
                                phase_next = PH_OFFSET;
                            end
                        end
                        else
                        begin
                            phase_next = PH_PIXEL;
                        end
                    end
                end
                PH_PIXEL:
                begin
                    // emit the pixel, widening each channel
                    has_result         = 1'b1;
                    result_next.kind   = srld_pkg::KIND_PIXEL;
                    result_next.pixel_x = column_reg[srld_pkg::COORD_W-1:0];
                    result_next.pixel_y = line_index_reg[srld_pkg::COORD_W-1:0];
                    result_next.red    = {in_word_reg[15:11], 3'b000};
                    result_next.green  = {in_word_reg[10:5], 2'b00};
                    result_next.blue   = {in_word_reg[4:0], 3'b000};
                    column_next        = column_reg + DW'(1);
                    pixels_left_next   = pixels_dec;
                    if (pixels_dec == 16'd0)
                    begin
                        runs_left_next = runs_dec;
                        if (runs_dec == 16'd0)
                        begin
                            line_index_next       = line_inc;
                            column_next           = '0;
                            phase_next            = line_last ? PH_HOLD : PH_RUNCOUNT;
                            result_next.frame_end = line_last;
                        end
                        else
                        begin
                            phase_next = PH_OFFSET;
                        end
                    end
                end
                default:
                begin
                    // idle or holding: word is dropped
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DW'(1);
            frame_height_reg <= DW'(1);
            frame_words_reg  <= WW'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                srld_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DW-1:0];
                srld_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DW-1:0];
                srld_pkg::CFG_FRAME_WORDS:  frame_words_reg  <= cfg_data[WW-1:0];
                default:                    frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // input stage, parse state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            phase_reg         <= PH_IDLE;
            line_index_reg    <= '0;
            column_reg        <= '0;
            runs_left_reg     <= '0;
            pixels_left_reg   <= '0;
            word_position_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg         <= phase_next;
                line_index_reg    <= line_index_next;
                column_reg        <= column_next;
                runs_left_reg     <= runs_left_next;
                pixels_left_reg   <= pixels_left_next;
                word_position_reg <= word_position_next;
            end

            if (advance && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_start_reg <= frame_start;
            in_word_reg  <= data_word;
        end
        if (advance && has_result)
        begin
            result_reg <= result_next;
        end
    end

    // result ports
    assign kind       = result_reg.kind;
    assign pixel_x    = result_reg.pixel_x;
    assign pixel_y    = result_reg.pixel_y;
    assign red        = result_reg.red;
    assign green      = result_reg.green;
    assign blue       = result_reg.blue;
    assign frame_end  = result_reg.frame_end;
    assign error_code = result_reg.error_code;

    // checks
`include "sprite_run_length_decoder_top_assert.svh"

    `SRLD_ASSERT_IMPLY(a_err_beat, result_valid && (kind == srld_pkg::KIND_ERROR), !frame_end && (error_code != srld_pkg::ERR_NONE))
    `SRLD_ASSERT_IMPLY(a_pixels_live, phase_reg == PH_PIXEL, pixels_left_reg != 16'd0)
    `SRLD_ASSERT_IMPLY(a_runs_live, (phase_reg == PH_OFFSET) || (phase_reg == PH_LENGTH), runs_left_reg != 16'd0)
    `SRLD_ASSERT_NEXT(a_stage_hold, in_valid_reg && !advance, in_valid_reg && $stable(in_word_reg))

endmodule

`default_nettype wire

/* dv/sprite_run_length_decoder_checker.sv */
// result checker for the sprite run-length decoder: follows the word, result and
// register write channels, predicts every result beat and compares it field by field
// depends on srld_pkg
`timescale 1ns / 1ps

module sprite_run_length_decoder_checker #(
    parameter int unsigned MAX_DIMENSION   = 4096,
    parameter int unsigned MAX_FRAME_WORDS = 1048576
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        word_valid,
    input  logic        word_stall,
    input  logic        frame_start,
    input  logic [15:0] data_word,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [1:0]  kind,
    input  logic [11:0] pixel_x,
    input  logic [11:0] pixel_y,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        frame_end,
    input  logic [2:0]  error_code,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    output int          mismatch_count,
    output int          pending_count,
    output int          pixel_beats,
    output int          done_beats,
    output int          error_beats
);

    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_RUN_COUNT,
        STEP_OFFSET,
        STEP_LENGTH,
        STEP_PIXEL,
        STEP_HOLD
    } parse_step_t;

    // register copies as last written
    int unsigned reg_width;
    int unsigned reg_height;
    int unsigned reg_words;

    // parser state
    parse_step_t step;
    int unsigned line_idx;
    int unsigned col;
    int unsigned runs_left;
    int unsigned pixels_left;
    int unsigned word_pos;

    // result beats still owed by the block, oldest first
    srld_pkg::result_t expected_beats[$];
    srld_pkg::result_t predicted;
    srld_pkg::result_t got;
    srld_pkg::result_t want;

    string field_names [8] = '{"kind", "pixel_x", "pixel_y", "red", "green", "blue",
                               "frame_end", "error_code"};

    function automatic int unsigned clamp(int unsigned v, int unsigned m);
        return (v > m) ? m : v;
    endfunction

    function automatic srld_pkg::result_t make_beat(srld_pkg::kind_t k, int unsigned x,
                                                    int unsigned y, logic [15:0] rgb,
                                                    logic fend, srld_pkg::err_t e);
        srld_pkg::result_t r;
        r = '0;
        r.kind       = k;
        r.frame_end  = fend;
        r.error_code = e;
        // position and colour only travel with a pixel
        if (k == srld_pkg::KIND_PIXEL)
        begin
            r.pixel_x = x[11:0];
            r.pixel_y = y[11:0];
            r.red     = {rgb[15:11], 3'b000};
            r.green   = {rgb[10:5], 2'b00};
            r.blue    = {rgb[4:0], 3'b000};
        end
        return r;
    endfunction

    // report an error and ignore words until the next frame start
    function automatic srld_pkg::result_t flag_error(srld_pkg::err_t e);
        step = STEP_HOLD;
        return make_beat(srld_pkg::KIND_ERROR, 0, 0, '0, 1'b0, e);
    endfunction

    // close the current line; 1 when it was the last one
    function automatic bit close_line();
        line_idx = (line_idx + 1) & 32'h1fff;
        col = 0;
        if (line_idx >= clamp(reg_height, MAX_DIMENSION))
        begin
            step = STEP_HOLD;
            return 1'b1;
        end
        step = STEP_RUN_COUNT;
        return 1'b0;
    endfunction

    // close the current run; 1 when the frame ended with it
    function automatic bit close_run();
        runs_left = (runs_left - 1) & 32'hffff;
        if (runs_left == 0)
            return close_line();
        step = STEP_OFFSET;
        return 1'b0;
    endfunction

    // one word through the parser; 1 when it yields a result beat
    function automatic bit decode_word(input logic start, input logic [15:0] w,
                                       output srld_pkg::result_t beat);
        int unsigned width;
        int unsigned height;
        int unsigned word_limit;
        int unsigned pos;
        int unsigned wv;
        int unsigned x;
        int unsigned y;
        bit          fin;
        width      = clamp(reg_width, MAX_DIMENSION);
        height     = clamp(reg_height, MAX_DIMENSION);
        word_limit = clamp(reg_words, MAX_FRAME_WORDS);
        wv         = 32'(w);
        beat       = '0;

        // frame start restarts the parse from any step
        if (start)
        begin
            line_idx    = 0;
            col         = 0;
            runs_left   = 0;
            pixels_left = 0;
            word_pos    = 1;
            if (wv != height)
            begin
                beat = flag_error(srld_pkg::ERR_LINE_MISMATCH);
                return 1'b1;
            end
            if (height == 0)
            begin
                step = STEP_HOLD;
                beat = make_beat(srld_pkg::KIND_DONE, 0, 0, '0, 1'b1, srld_pkg::ERR_NONE);
                return 1'b1;
            end
            step = STEP_RUN_COUNT;
            return 1'b0;
        end

        if (step == STEP_IDLE || step == STEP_HOLD)
            return 1'b0;

        pos      = word_pos;
        word_pos = (word_pos + 1) & 32'h1fffff;

        case (step)
            STEP_RUN_COUNT:
            begin
                if (pos >= word_limit)
                begin
                    beat = flag_error(srld_pkg::ERR_RUNCOUNT_OVR);
                    return 1'b1;
                end
                runs_left = wv;
                // empty line
                if (wv == 0)
                begin
                    if (close_line())
                    begin
                        beat = make_beat(srld_pkg::KIND_DONE, 0, 0, '0, 1'b1,
                                         srld_pkg::ERR_NONE);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                step = STEP_OFFSET;
                return 1'b0;
            end
            STEP_OFFSET:
            begin
                if (pos + 2 > word_limit)
                begin
                    beat = flag_error(srld_pkg::ERR_HEADER_OVR);
                    return 1'b1;
                end
                if (col + wv > width)
                begin
                    beat = flag_error(srld_pkg::ERR_OFFSET_WIDE);
                    return 1'b1;
                end
                col  = (col + wv) & 32'h1fff;
                step = STEP_LENGTH;
                return 1'b0;
            end
            STEP_LENGTH:
            begin
                if (pos + 1 + wv > word_limit)
                begin
                    beat = flag_error(srld_pkg::ERR_DATA_OVR);
                    return 1'b1;
                end
                if (col + wv > width)
                begin
                    beat = flag_error(srld_pkg::ERR_DATA_WIDE);
                    return 1'b1;
                end
                pixels_left = wv;
                // zero-length run
                if (wv == 0)
                begin
                    if (close_run())
                    begin
                        beat = make_beat(srld_pkg::KIND_DONE, 0, 0, '0, 1'b1,
                                         srld_pkg::ERR_NONE);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                step = STEP_PIXEL;
                return 1'b0;
            end
            default:
            begin
                x           = col;
                y           = line_idx;
                col         = (col + 1) & 32'h1fff;
                pixels_left = (pixels_left - 1) & 32'hffff;
                fin         = 1'b0;
                if (pixels_left == 0)
                    fin = close_run();
                beat = make_beat(srld_pkg::KIND_PIXEL, x, y, w, fin, srld_pkg::ERR_NONE);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic logic [11:0] field_of(srld_pkg::result_t r, int i);
        case (i)
            0:       return 12'(r.kind);
            1:       return r.pixel_x;
            2:       return r.pixel_y;
            3:       return 12'(r.red);
            4:       return 12'(r.green);
            5:       return 12'(r.blue);
            6:       return 12'(r.frame_end);
            default: return 12'(r.error_code);
        endcase
    endfunction

    // prediction and comparison, one pass per edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_width   = 1;
            reg_height  = 1;
            reg_words   = 1;
            step        = STEP_IDLE;
            line_idx    = 0;
            col         = 0;
            runs_left   = 0;
            pixels_left = 0;
            word_pos    = 0;
            expected_beats.delete();
            pending_count = 0;
        end
        else
        begin
            // register write beat
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    srld_pkg::CFG_FRAME_WIDTH:  reg_width  = 32'(cfg_data[12:0]);
                    srld_pkg::CFG_FRAME_HEIGHT: reg_height = 32'(cfg_data[12:0]);
                    srld_pkg::CFG_FRAME_WORDS:  reg_words  = 32'(cfg_data);
                    default:                    ;
                endcase
            end

            // accepted word beat
            if (word_valid && !word_stall)
            begin
                if (decode_word(frame_start, data_word, predicted))
                    expected_beats.push_back(predicted);
            end

            // accepted result beat
            if (result_valid && !result_stall)
            begin
                got.kind       = srld_pkg::kind_t'(kind);
                got.pixel_x    = pixel_x;
                got.pixel_y    = pixel_y;
                got.red        = red;
                got.green      = green;
                got.blue       = blue;
                got.frame_end  = frame_end;
                got.error_code = srld_pkg::err_t'(error_code);
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, kind %0d x %0d y %0d error %0d",
                             $time, kind, pixel_x, pixel_y, error_code);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    for (int i = 0; i < 8; i++)
                    begin
                        if (field_of(want, i) !== field_of(got, i))
                        begin
                            $display("%0t: %s expected %0d, got %0d", $time, field_names[i],
                                     field_of(want, i), field_of(got, i));
                            mismatch_count++;
                        end
                    end
                end
                case (kind)
                    srld_pkg::KIND_PIXEL: pixel_beats++;
                    srld_pkg::KIND_DONE:  done_beats++;
                    default:              error_beats++;
                endcase
            end
            pending_count = expected_beats.size();
        end
    end

endmodule

/* dv/sprite_run_length_decoder_top_tb.sv */
// testbench top for the sprite run-length decoder: clock, reset, register writes,
// directed and random frame streams, random stalls; checking is done by
// sprite_run_length_decoder_checker; depends on srld_pkg and the block
`timescale 1ns / 1ps

module sprite_run_length_decoder_top_tb;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          WORD_TARGET = 1300;
    localparam int          HOLD_CYCLES = 300;
    localparam int unsigned DIM_CAP     = 4096;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        word_valid;
    logic        word_stall;
    logic        frame_start;
    logic [15:0] data_word;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        frame_end;
    logic [2:0]  error_code;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [19:0] cfg_data;

    int mismatch_count;
    int pending_count;
    int pixel_beats;
    int done_beats;
    int error_beats;

    bit          idle_enable  = 1'b1;
    bit          hold_request = 1'b0;
    bit          hold_done    = 1'b0;
    int          hold_left    = 0;
    int          cycle_count  = 0;
    int          frame_beats  = 0;
    int          frames_sent  = 0;
    int          settings_used = 0;
    int unsigned width_reg;
    int unsigned height_reg;

    sprite_run_length_decoder_top dut (
        .clk, .rst_n,
        .word_valid, .word_stall, .frame_start, .data_word,
        .result_valid, .result_stall, .kind, .pixel_x, .pixel_y,
        .red, .green, .blue, .frame_end, .error_code,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    sprite_run_length_decoder_checker checker_inst (
        .clk, .rst_n,
        .word_valid, .word_stall, .frame_start, .data_word,
        .result_valid, .result_stall, .kind, .pixel_x, .pixel_y,
        .red, .green, .blue, .frame_end, .error_code,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .mismatch_count, .pending_count, .pixel_beats, .done_beats, .error_beats
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (hold_request && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= idle_enable && ($urandom_range(0, 99) < 25);
    end

    // offer one word beat, with random idle cycles ahead of it
    task automatic send_word(input logic s, input logic [15:0] w);
        while (idle_enable && $urandom_range(0, 99) < 25)
        begin
            word_valid <= 1'b0;
            @(negedge clk);
        end
        word_valid  <= 1'b1;
        frame_start <= s;
        data_word   <= w;
        do
            @(posedge clk);
        while (word_stall);
        @(negedge clk);
    endtask

    task automatic wait_cfg_accept();
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // program all three registers back to back
    task automatic write_config(input int unsigned w, input int unsigned h,
                                input int unsigned n);
        cfg_valid <= 1'b1;
        cfg_index <= srld_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= 20'(w);
        wait_cfg_accept();
        cfg_index <= srld_pkg::CFG_FRAME_HEIGHT;
        cfg_data  <= 20'(h);
        wait_cfg_accept();
        cfg_index <= srld_pkg::CFG_FRAME_WORDS;
        cfg_data  <= 20'(n);
        wait_cfg_accept();
        cfg_valid <= 1'b0;
        width_reg  = w;
        height_reg = h;
        settings_used++;
    endtask

    // let every owed result arrive, then give words without one time to clear the block
    task automatic wait_drained();
        word_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        @(negedge clk);
    endtask

    // frame word, now and then damaged in a broken frame
    task automatic send_frame_word(input logic s, input int unsigned w, input bit broken);
        if (broken && $urandom_range(0, 15) == 0)
            w = $urandom_range(0, 1) ? w + $urandom_range(1, 2) : $urandom_range(0, 16'hffff);
        frame_beats++;
        send_word(s, w[15:0]);
    endtask

    // one frame laid out for the current registers
    task automatic send_frame(input bit broken);
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned lines;
        int unsigned runs;
        int unsigned used;
        int unsigned remaining;
        int unsigned offset;
        int unsigned len;
        w_eff = (width_reg > DIM_CAP) ? DIM_CAP : width_reg;
        h_eff = (height_reg > DIM_CAP) ? DIM_CAP : height_reg;
        // tall frames are abandoned after a few lines by the next frame start
        lines = (h_eff > 5) ? $urandom_range(1, 5) : h_eff;
        if (broken && $urandom_range(0, 1))
            lines = $urandom_range(0, lines);
        frames_sent++;
        send_frame_word(1'b1, h_eff, broken);
        for (int ln = 0; ln < lines; ln++)
        begin
            runs = $urandom_range(0, 3);
            used = 0;
            send_frame_word(1'b0, runs, broken);
            for (int r = 0; r < runs; r++)
            begin
                remaining = w_eff - used;
                if ($urandom_range(0, 3) == 0)
                    offset = $urandom_range(0, remaining);
                else
                    offset = $urandom_range(0, (remaining < 3) ? remaining : 3);
                len = $urandom_range(0, (remaining - offset < 6) ? remaining - offset : 6);
                send_frame_word(1'b0, offset, broken);
                send_frame_word(1'b0, len, broken);
                repeat (len) send_frame_word(1'b0, $urandom_range(0, 16'hffff), broken);
                used += offset + len;
            end
        end
        // trailing words, ignored by the block only once the frame has ended or failed
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_word(1'b0, 16'($urandom_range(0, 16'hffff)));
    endtask

    initial
    begin
        int phase;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        rst_n       = 1'b0;
        word_valid  = 1'b0;
        frame_start = 1'b0;
        data_word   = '0;
        cfg_valid   = 1'b0;
        cfg_index   = srld_pkg::CFG_FRAME_WIDTH;
        cfg_data    = '0;
        width_reg   = 1;
        height_reg  = 1;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: stray word before any frame, then run count overrun
        send_word(1'b0, 16'hffff);
        send_word(1'b1, 16'd1);
        send_word(1'b0, 16'd3);
        wait_drained();

        // zero height: matching line count finishes at once, any other mismatches
        write_config(8191, 0, 0);
        send_word(1'b1, 16'd0);
        send_word(1'b1, 16'd5);
        wait_drained();

        // capped width: pixel at the last column, empty last line ends the frame
        write_config(8191, 2, 20);
        send_word(1'b1, 16'd2);
        send_word(1'b0, 16'd1);
        send_word(1'b0, 16'd4095);
        send_word(1'b0, 16'd1);
        send_word(1'b0, 16'hffff);
        send_word(1'b0, 16'd0);
        // offset past the width
        send_word(1'b1, 16'd2);
        send_word(1'b0, 16'd1);
        send_word(1'b0, 16'd4097);
        // run past the width
        send_word(1'b1, 16'd2);
        send_word(1'b0, 16'd1);
        send_word(1'b0, 16'd4090);
        send_word(1'b0, 16'd7);
        // run past the frame's words
        send_word(1'b1, 16'd2);
        send_word(1'b0, 16'd1);
        send_word(1'b0, 16'd0);
        send_word(1'b0, 16'd97);
        wait_drained();

        // zero-length run mid line, then run header past the frame's words
        write_config(4, 1, 4);
        send_word(1'b1, 16'd1);
        send_word(1'b0, 16'd2);
        send_word(1'b0, 16'd0);
        send_word(1'b0, 16'd0);
        send_word(1'b0, 16'd0);
        // zero-length run closing the last line
        send_word(1'b1, 16'd1);
        send_word(1'b0, 16'd1);
        send_word(1'b0, 16'd1);
        send_word(1'b0, 16'd0);

        // random frames, mostly well formed, one setting per phase
        phase = 0;
        while (frame_beats < WORD_TARGET)
        begin
            wait_drained();
            case ($urandom_range(0, 9))
                0:       w = DIM_CAP;
                1:       w = 8191;
                2:       w = $urandom_range(1, 8191);
                default: w = $urandom_range(1, 20);
            endcase
            case ($urandom_range(0, 9))
                0:       h = 0;
                1:       h = $urandom_range(0, 1) ? DIM_CAP : 8191;
                default: h = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 5))
                0:       n = $urandom_range(0, 40);
                1:       n = 20'hfffff;
                default: n = $urandom_range(200, 20'hfffff);
            endcase
            // pixel-rich setting while the result side holds off
            if (phase == 1)
            begin
                w = 16;
                h = 4;
                n = 20'hfffff;
                hold_request = 1'b1;
            end
            write_config(w, h, n);
            idle_enable = (phase != 3);
            repeat ((phase == 3) ? 12 : $urandom_range(3, 8))
                send_frame($urandom_range(0, 3) == 0);
            phase++;
        end
        idle_enable = 1'b1;
        wait_drained();

        $display("sent %0d random frame words in %0d frames over %0d register settings",
                 frame_beats, frames_sent, settings_used);
        $display("checked %0d pixels, %0d empty frame ends and %0d error reports",
                 pixel_beats, done_beats, error_beats);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
